[rtl/core/skbs_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the
// sorted key binary search block. No dependencies.
package skbs_pkg;

  localparam int RECORD_DEPTH = 65536;
  localparam int ADDR_W       = $clog2(RECORD_DEPTH);
  localparam int CNT_W        = $clog2(RECORD_DEPTH + 1);
  localparam int KEY_W        = 72;
  localparam int LEAD_W       = 8;
  localparam int TAIL_W       = 64;
  localparam int EIDX_W       = 16;
  localparam int RIDX_W       = 16;
  localparam int RCNT_W       = 17;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic start;
    logic write;
    logic probe;
    logic step;
    logic finish;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic more;
  } dp_sts_t;

endpackage

[rtl/core/skbs_if.sv]
// Valid/ready channel interfaces for the item input and the result output.
// Depends on skbs_pkg.
interface skbs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [skbs_pkg::EIDX_W-1:0] entry_index;
  logic [skbs_pkg::LEAD_W-1:0] key_lead;
  logic [skbs_pkg::TAIL_W-1:0] key_tail;

  modport source (output valid, command, entry_index, key_lead, key_tail, input ready);
  modport sink   (input valid, command, entry_index, key_lead, key_tail, output ready);
endinterface

interface skbs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [skbs_pkg::RIDX_W-1:0] record_index;

  modport source (output valid, found, record_index, input ready);
  modport sink   (input valid, found, record_index, output ready);
endinterface

[rtl/core/skbs_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module skbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/skbs_datapath.sv]
// Datapath: record count register, key store, search window, compare and
// result registers. Depends on skbs_pkg and skbs_ram.
module skbs_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        record_count_wr_en,
  input  logic [skbs_pkg::RCNT_W-1:0] record_count_wr_data,
  input  logic                        command,
  input  logic [skbs_pkg::EIDX_W-1:0] entry_index,
  input  logic [skbs_pkg::LEAD_W-1:0] key_lead,
  input  logic [skbs_pkg::TAIL_W-1:0] key_tail,
  input  skbs_pkg::ctl_cmd_t          cmd,
  output skbs_pkg::dp_sts_t           sts,
  output logic                        found,
  output logic [skbs_pkg::RIDX_W-1:0] record_index
);

  logic [skbs_pkg::RCNT_W-1:0] record_count;
  logic [skbs_pkg::KEY_W-1:0]  target;
  logic [skbs_pkg::CNT_W-1:0]  low;
  logic [skbs_pkg::CNT_W-1:0]  high;
  logic [skbs_pkg::ADDR_W-1:0] probe;
  logic                        first;
  logic                        found_r;
  logic [skbs_pkg::RIDX_W-1:0] index_r;

  logic [skbs_pkg::CNT_W-1:0]  count_eff;
  logic [skbs_pkg::KEY_W-1:0]  rdata;
  logic [skbs_pkg::ADDR_W-1:0] ram_addr;
  logic                        ram_we;
  logic                        in_range;
  logic                        eq;
  logic                        gt;
  logic [skbs_pkg::CNT_W-1:0]  low_next;
  logic [skbs_pkg::CNT_W-1:0]  high_next;
  logic [skbs_pkg::CNT_W:0]    mid_sum;
  logic [skbs_pkg::ADDR_W-1:0] mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_count <= '0;
    end else if (record_count_wr_en) begin
      record_count <= record_count_wr_data;
    end
  end

  assign count_eff = (32'(record_count) > 32'(skbs_pkg::RECORD_DEPTH))
                   ? skbs_pkg::CNT_W'(skbs_pkg::RECORD_DEPTH)
                   : skbs_pkg::CNT_W'(record_count);
  assign in_range  = 32'(entry_index) < 32'(skbs_pkg::RECORD_DEPTH);
  assign ram_we    = cmd.write && in_range;

  assign eq = target == rdata;
  assign gt = target > rdata;

  always_comb begin
    if (first || gt) begin
      low_next = first ? low : skbs_pkg::CNT_W'(probe);
      high_next = high;
    end else begin
      low_next = low;
      high_next = skbs_pkg::CNT_W'(probe);
    end
  end

  assign mid_sum = (skbs_pkg::CNT_W + 1)'(low_next) + (skbs_pkg::CNT_W + 1)'(high_next);
  assign mid     = skbs_pkg::ADDR_W'(mid_sum >> 1);

  assign sts.count_zero = record_count == '0;
  assign sts.more = !eq && (gt || !first)
                 && ((high_next - low_next) > skbs_pkg::CNT_W'(1));

  always_comb begin
    if (cmd.probe) begin
      ram_addr = mid;
    end else if (command == skbs_pkg::CMD_LOOKUP) begin
      ram_addr = '0;
    end else begin
      ram_addr = skbs_pkg::ADDR_W'(entry_index);
    end
  end

  skbs_ram #(
    .WIDTH(skbs_pkg::KEY_W),
    .DEPTH(skbs_pkg::RECORD_DEPTH)
  ) u_key_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata({key_lead, key_tail}),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target  <= {key_lead, key_tail};
      low     <= '0;
      high    <= count_eff;
      probe   <= '0;
      first   <= 1'b1;
      found_r <= 1'b0;
      index_r <= '0;
    end else if (cmd.step) begin
      low   <= low_next;
      high  <= high_next;
      probe <= mid;
      first <= 1'b0;
    end else if (cmd.finish) begin
      found_r <= eq;
      index_r <= eq ? skbs_pkg::RIDX_W'(probe) : '0;
    end
    if (cmd.out_load) begin
      found        <= found_r;
      record_index <= index_r;
    end
  end

endmodule

[rtl/core/skbs_ctrl.sv]
// Controller state machine: accepts items, sequences probes, loads the
// output register. Depends on skbs_pkg.
module skbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  skbs_pkg::dp_sts_t  sts,
  output skbs_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   slot_free;

  assign in_ready  = state == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && in_command == skbs_pkg::CMD_LOOKUP) begin
          cmd.start  = 1'b1;
          state_next = sts.count_zero ? S_EMIT : S_SEARCH;
        end else if (accept) begin
          cmd.write = 1'b1;
        end
      end
      S_SEARCH: begin
        cmd.probe = 1'b1;
        if (sts.more) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/sorted_key_binary_search_top.sv]
// Sorted key binary search over a 65536 x 72-bit key store.
// Load item: writes one key at entry_index into the key store, returns nothing.
// Lookup item: accepted, then key store probes (entry zero plus up to
// ceil(log2(record_count)) halvings, none if record_count is zero), then the result load.
// A new item is taken only in the idle state, after the previous result has been loaded.
// Reset clears control and record_count; the key store is not cleared.
module sorted_key_binary_search_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        record_count_wr_en,
  input  logic [skbs_pkg::RCNT_W-1:0] record_count_wr_data,
  skbs_in_if.sink                     ingress,
  skbs_out_if.source                  egress
);

  skbs_pkg::ctl_cmd_t cmd;
  skbs_pkg::dp_sts_t  sts;
  logic               in_ready;
  logic               out_valid;

  assign ingress.ready = in_ready;
  assign egress.valid  = out_valid;

  skbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ingress.valid),
    .in_command(ingress.command),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (egress.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skbs_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .record_count_wr_en  (record_count_wr_en),
    .record_count_wr_data(record_count_wr_data),
    .command             (ingress.command),
    .entry_index         (ingress.entry_index),
    .key_lead            (ingress.key_lead),
    .key_tail            (ingress.key_tail),
    .cmd                 (cmd),
    .sts                 (sts),
    .found               (egress.found),
    .record_index        (egress.record_index)
  );

endmodule
